// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked, with reset as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kdpc_pkg
// Types, constants and codes of the key debounce / press classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kdpc_pkg;

  localparam int NUM_KEYS  = 3;
  localparam int KEY_W     = 2;
  localparam int TIME_W    = 32;
  localparam int SCORE_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(TIME_W);

  localparam logic [SCORE_W-1:0] INST_UP   = SCORE_W'(3);
  localparam logic [SCORE_W-1:0] INST_DOWN = SCORE_W'(1);
  localparam logic [SCORE_W-1:0] INST_FLIP = SCORE_W'(8);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = CFG_IDX_W'(2);

  localparam logic [TIME_W-1:0] SHORT_RST  = TIME_W'(350);
  localparam logic [TIME_W-1:0] LONG_RST   = TIME_W'(700);
  localparam logic [TIME_W-1:0] REPEAT_RST = TIME_W'(200);

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SHORT  = 2'd1,
    ACT_LONG   = 2'd2,
    ACT_REPEAT = 2'd3
  } press_action_t;

  // One key's stored state
  typedef struct packed {
    logic              stable;
    logic [TIME_W-1:0] change_time;
    logic [SCORE_W-1:0] score;
  } entry_t;

  localparam entry_t ENTRY_RST = '{stable: 1'b1, change_time: '0, score: '0};

  typedef struct packed {
    logic             rd_en;
    logic [KEY_W-1:0] rd_addr;
    logic             wr_en;
    logic [KEY_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_rsp_t;

endpackage

// ===== rtl/kdpc_in_if.sv =====
// ----------------------------------------------------------------------------
// kdpc_in_if
// Sample channel: one poll sample of one key per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kdpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [kdpc_pkg::KEY_W-1:0]    key_index;
  logic                          raw_level;
  logic [kdpc_pkg::TIME_W-1:0]   now_ms;
  logic                          initialize;

  modport source (output valid, key_index, raw_level, now_ms, initialize, input ready);
  modport sink   (input valid, key_index, raw_level, now_ms, initialize, output ready);
endinterface

// ===== rtl/kdpc_out_if.sv =====
// ----------------------------------------------------------------------------
// kdpc_out_if
// Result channel: debounced state and press classification per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kdpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [kdpc_pkg::KEY_W-1:0]    key_id;
  logic [kdpc_pkg::TIME_W-1:0]   held_ms;
  logic                          pressed;
  logic                          changed;
  logic [1:0]                    press_action;

  modport source (output valid, key_id, held_ms, pressed, changed, press_action,
                  input ready);
  modport sink   (input valid, key_id, held_ms, pressed, changed, press_action,
                  output ready);
endinterface

// ===== rtl/kdpc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// kdpc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kdpc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [kdpc_pkg::CFG_IDX_W-1:0]   index;
  logic [kdpc_pkg::TIME_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/key_debounce_press_classifier_top.sv =====
// An initialize item or one for an unknown key is taken and gives no result.
// Other items: the key state is read at accept, updated and written back, then the result
// is registered; the repeat test first waits for the remainder unit, which resolves one bit
// of a 32-bit word per cycle. One item at a time, taken from the cycle after the previous
// result is registered; the result register waits while the output stalls.
// Reset (rst_n, synchronous): registers to 350/700/200, all keys released, no result pending.
// ----------------------------------------------------------------------------
// key_debounce_press_classifier_top
// Per-key debouncer with press-duration classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module key_debounce_press_classifier_top (
  input  logic       clk,
  input  logic       rst_n,
  kdpc_in_if.sink    in_ch,
  kdpc_out_if.source out_ch,
  kdpc_cfg_if.sink   cfg_ch
);

  kdpc_pkg::mem_req_t mem_req;
  kdpc_pkg::entry_t   rd_entry;
  kdpc_pkg::div_req_t div_req;
  kdpc_pkg::div_rsp_t div_rsp;

  // Sequencer
  kdpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_ch   (cfg_ch),
    .mem_req  (mem_req),
    .rd_entry (rd_entry),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  // Key state memory
  kdpc_state_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd_entry (rd_entry)
  );

  // Repeat period remainder
  kdpc_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  `ASSERT_SAME(a_rw_excl, clk, rst_n, mem_req.rd_en, !mem_req.wr_en, "read and write-back overlap")
  `ASSERT_NEXT(a_busy_after_rd, clk, rst_n, mem_req.rd_en, !in_ch.ready, "item taken during update")
  `ASSERT_SAME(a_div_busy, clk, rst_n, div_rsp.done, !in_ch.ready, "remainder done while idle")

endmodule

// ===== rtl/kdpc_state_mem.sv =====
// ----------------------------------------------------------------------------
// kdpc_state_mem
// Per-key state memory, registered read; unwritten keys read as reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdpc_state_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  kdpc_pkg::mem_req_t req,
  output kdpc_pkg::entry_t   rd_entry
);

  kdpc_pkg::entry_t                 mem [kdpc_pkg::NUM_KEYS];
  logic [kdpc_pkg::NUM_KEYS-1:0]    vld_r;
  kdpc_pkg::entry_t                 rd_data_r;
  logic                             rd_vld_r;

  // Storage array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // Written flags; a never-written key returns the reset entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_entry = rd_vld_r ? rd_data_r : kdpc_pkg::ENTRY_RST;

endmodule

// ===== rtl/kdpc_mod_unit.sv =====
// ----------------------------------------------------------------------------
// kdpc_mod_unit
// Restoring remainder unit, one quotient bit per cycle; reports a zero remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdpc_mod_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  kdpc_pkg::div_req_t req,
  output kdpc_pkg::div_rsp_t rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [kdpc_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [kdpc_pkg::TIME_W-1:0]       rem_r;
  logic [kdpc_pkg::TIME_W-1:0]       dvd_r;
  logic [kdpc_pkg::TIME_W-1:0]       dvs_r;
  logic [kdpc_pkg::TIME_W:0]         trial;
  logic [kdpc_pkg::TIME_W:0]         diff;
  logic [kdpc_pkg::TIME_W-1:0]       rem_nxt;

  // One restoring step
  always_comb begin
    trial   = {rem_r, dvd_r[kdpc_pkg::TIME_W-1]};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = diff[kdpc_pkg::TIME_W] ? trial[kdpc_pkg::TIME_W-1:0]
                                     : diff[kdpc_pkg::TIME_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == kdpc_pkg::DIV_CNT_W'(kdpc_pkg::TIME_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[kdpc_pkg::TIME_W-2:0], 1'b0};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.rem_zero = (rem_r == '0);

endmodule

// ===== rtl/kdpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kdpc_ctrl
// Sequencer: read-modify-write of key state, classification, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdpc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  kdpc_in_if.sink            in_ch,
  kdpc_out_if.source         out_ch,
  kdpc_cfg_if.sink           cfg_ch,
  output kdpc_pkg::mem_req_t mem_req,
  input  kdpc_pkg::entry_t   rd_entry,
  output kdpc_pkg::div_req_t div_req,
  input  kdpc_pkg::div_rsp_t div_rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                          state_r;
  logic [kdpc_pkg::TIME_W-1:0]     short_r;
  logic [kdpc_pkg::TIME_W-1:0]     long_r;
  logic [kdpc_pkg::TIME_W-1:0]     repeat_r;

  // Latched sample
  logic [kdpc_pkg::KEY_W-1:0]      key_r;
  logic                            raw_r;
  logic [kdpc_pkg::TIME_W-1:0]     now_r;

  // Pending result
  logic [kdpc_pkg::KEY_W-1:0]      res_key_r;
  logic [kdpc_pkg::TIME_W-1:0]     res_held_r;
  logic                            res_pressed_r;
  logic                            res_changed_r;
  kdpc_pkg::press_action_t         res_act_r;

  // Output register
  logic                            out_valid_r;
  logic [kdpc_pkg::KEY_W-1:0]      out_key_r;
  logic [kdpc_pkg::TIME_W-1:0]     out_held_r;
  logic                            out_pressed_r;
  logic                            out_changed_r;
  kdpc_pkg::press_action_t         out_act_r;

  logic                            in_acc;
  logic                            key_ok;
  logic [kdpc_pkg::TIME_W-1:0]     held;
  logic                            mismatch;
  logic [kdpc_pkg::SCORE_W-1:0]    score;
  logic                            flip;
  kdpc_pkg::entry_t                upd;
  logic                            is_short;
  logic                            is_long;
  logic                            need_div;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign key_ok       = (in_ch.key_index < kdpc_pkg::KEY_W'(kdpc_pkg::NUM_KEYS));

  // Score update and classification on the entry just read
  always_comb begin
    held     = now_r - rd_entry.change_time;
    mismatch = (raw_r != rd_entry.stable);
    if (mismatch) begin
      score = rd_entry.score + kdpc_pkg::INST_UP;
    end else if (rd_entry.score != '0) begin
      score = rd_entry.score - kdpc_pkg::INST_DOWN;
    end else begin
      score = '0;
    end
    flip = (score >= kdpc_pkg::INST_FLIP);
    upd.stable      = flip ? raw_r : rd_entry.stable;
    upd.change_time = flip ? now_r : rd_entry.change_time;
    upd.score       = flip ? '0 : score;
    is_short = (held < short_r);
    is_long  = (held < long_r);
    need_div = !is_short && !is_long && (repeat_r != '0);
  end

  // Memory requests: init write or read at accept, write-back in update
  always_comb begin
    mem_req         = '0;
    mem_req.rd_addr = in_ch.key_index;
    mem_req.rd_en   = in_acc && key_ok && !in_ch.initialize;
    if (state_r == ST_UPDATE) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = key_r;
      mem_req.wr_data = upd;
    end else begin
      mem_req.wr_en   = in_acc && key_ok && in_ch.initialize;
      mem_req.wr_addr = in_ch.key_index;
      mem_req.wr_data = '{stable: in_ch.raw_level, change_time: in_ch.now_ms, score: '0};
    end
  end

  // Repeat tick test: (held - long) mod repeat
  always_comb begin
    div_req.start    = (state_r == ST_UPDATE) && need_div;
    div_req.dividend = held - long_r;
    div_req.divisor  = repeat_r;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r  <= kdpc_pkg::SHORT_RST;
      long_r   <= kdpc_pkg::LONG_RST;
      repeat_r <= kdpc_pkg::REPEAT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        kdpc_pkg::CFG_SHORT:  short_r  <= cfg_ch.data;
        kdpc_pkg::CFG_LONG:   long_r   <= cfg_ch.data;
        kdpc_pkg::CFG_REPEAT: repeat_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Emit state always leaves the output register full
      if (out_ch.ready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && key_ok && !in_ch.initialize) begin
            key_r   <= in_ch.key_index;
            raw_r   <= in_ch.raw_level;
            now_r   <= in_ch.now_ms;
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          res_key_r     <= key_r;
          res_held_r    <= held;
          res_pressed_r <= !upd.stable;
          res_changed_r <= flip;
          if (is_short) begin
            res_act_r <= kdpc_pkg::ACT_SHORT;
          end else if (is_long) begin
            res_act_r <= kdpc_pkg::ACT_LONG;
          end else begin
            res_act_r <= kdpc_pkg::ACT_NONE;
          end
          state_r <= need_div ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            res_act_r <= div_rsp.rem_zero ? kdpc_pkg::ACT_REPEAT : kdpc_pkg::ACT_NONE;
            state_r   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_key_r     <= res_key_r;
            out_held_r    <= res_held_r;
            out_pressed_r <= res_pressed_r;
            out_changed_r <= res_changed_r;
            out_act_r     <= res_act_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.key_id       = out_key_r;
  assign out_ch.held_ms      = out_held_r;
  assign out_ch.pressed      = out_pressed_r;
  assign out_ch.changed      = out_changed_r;
  assign out_ch.press_action = out_act_r;

endmodule
